// File: rtl/core/ths_pkg.sv
// Package for the timing health supervisor: request and result records,
// supervisor state record, op codes and status codes.
// No dependencies.
package ths_pkg;

    localparam logic [1:0]  ST_UNLOCK      = 2'd0;
    localparam logic [1:0]  ST_OK          = 2'd1;
    localparam logic [2:0]  GPS_DOG_LIMIT  = 3'd3;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
    localparam logic [31:0] HOLD_LIMIT_RST = 32'd3600;

    typedef enum logic [1:0] {
        H_UNLOCK = 2'd0,
        H_HOLD   = 2'd1,
        H_OK     = 2'd2
    } health_t;

    typedef enum logic [3:0] {
        OP_PLL      = 4'd0,
        OP_FLL      = 4'd1,
        OP_GPS      = 4'd2,
        OP_OSC      = 4'd3,
        OP_KICK_FLL = 4'd4,
        OP_KICK_GPS = 4'd5,
        OP_TICK     = 4'd6,
        OP_SET_REF  = 4'd7,
        OP_QUERY    = 4'd8
    } op_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  status_value;
        logic [31:0] ref_seconds;
        logic [31:0] ref_fraction;
        logic [31:0] now_seconds;
        logic [31:0] now_fraction;
    } item_t;

    typedef struct packed {
        logic [1:0]  pll;
        logic [1:0]  fll;
        logic [1:0]  gps;
        logic [1:0]  osc;
        health_t     health;
        logic [31:0] ref_sec;
        logic [31:0] ref_frac;
        logic [31:0] hold_sec;
        logic [31:0] hold_frac;
        logic [2:0]  gps_dog;
        logic [31:0] fll_dog;
        logic        pps_on;
    } sup_state_t;

    typedef struct packed {
        logic [1:0]  health_state;
        logic        pps_enabled;
        logic        holdover_entered;
        logic        holdover_left;
        logic [31:0] holdover_seconds;
        logic        run_pll;
        logic [31:0] ref_age_seconds;
    } result_t;

endpackage

// File: rtl/core/ths_step.sv
// Next-state and result logic of the timing health supervisor for one request.
// Depends on ths_pkg.
module ths_step (
    input  ths_pkg::item_t      item,
    input  ths_pkg::sup_state_t cur,
    input  logic [31:0]         hold_limit,
    output ths_pkg::sup_state_t nxt,
    output ths_pkg::result_t    res
);
    import ths_pkg::*;

    typedef struct packed {
        sup_state_t  st;
        logic        entered;
        logic        left;
        logic [31:0] secs;
    } eval_t;

    function automatic logic [31:0] age_from(logic [31:0] ns, logic [31:0] nf,
                                             logic [31:0] s, logic [31:0] f);
        return ns - s - {31'd0, (nf < f)};
    endfunction

    function automatic eval_t reeval(eval_t e, logic [31:0] ns, logic [31:0] nf);
        eval_t   r;
        health_t nh;
        r  = e;
        nh = e.st.health;
        if (e.st.health == H_OK && e.st.gps == ST_UNLOCK)
            nh = (e.st.fll == ST_OK) ? H_HOLD : H_UNLOCK;
        if (e.st.health == H_HOLD && e.st.fll == ST_UNLOCK)
            nh = H_UNLOCK;
        if (e.st.health != H_UNLOCK && (e.st.pll == ST_UNLOCK || e.st.osc == ST_UNLOCK))
            nh = H_UNLOCK;
        if (e.st.health != H_OK && e.st.pll == ST_OK && e.st.gps == ST_OK
            && e.st.osc == ST_OK)
            nh = H_OK;
        if (nh != e.st.health)
        begin
            case (nh)
                H_OK:
                begin
                    if (e.st.hold_sec != ALL_ONES || e.st.hold_frac != ALL_ONES)
                    begin
                        r.left = 1'b1;
                        r.secs = age_from(ns, nf, e.st.hold_sec, e.st.hold_frac);
                    end
                    r.st.pps_on = 1'b1;
                end
                H_HOLD:
                begin
                    r.st.hold_sec  = e.st.ref_sec;
                    r.st.hold_frac = e.st.ref_frac;
                    r.entered      = 1'b1;
                end
                default:
                    r.st.pps_on = 1'b0;
            endcase
            r.st.health = nh;
        end
        return r;
    endfunction

    eval_t e;
    logic  run;

    always_comb
    begin
        e.st      = cur;
        e.entered = 1'b0;
        e.left    = 1'b0;
        e.secs    = 32'd0;
        unique case (op_t'(item.op))
            OP_PLL:
            begin
                if (e.st.pll != item.status_value)
                begin
                    e.st.pll = item.status_value;
                    e = reeval(e, item.now_seconds, item.now_fraction);
                end
            end
            OP_FLL:
            begin
                if (e.st.fll != item.status_value)
                begin
                    e.st.fll = item.status_value;
                    e = reeval(e, item.now_seconds, item.now_fraction);
                end
            end
            OP_GPS:
            begin
                if (e.st.gps != item.status_value)
                begin
                    e.st.gps = item.status_value;
                    e = reeval(e, item.now_seconds, item.now_fraction);
                end
            end
            OP_OSC:
            begin
                if (e.st.osc != item.status_value)
                begin
                    e.st.osc = item.status_value;
                    e = reeval(e, item.now_seconds, item.now_fraction);
                end
            end
            OP_KICK_FLL: e.st.fll_dog = 32'd0;
            OP_KICK_GPS: e.st.gps_dog = 3'd0;
            OP_TICK:
            begin
                // GPS watchdog first, then FLL watchdog
                if (e.st.gps_dog <= GPS_DOG_LIMIT)
                    e.st.gps_dog = e.st.gps_dog + 3'd1;
                if (e.st.gps_dog == GPS_DOG_LIMIT && e.st.gps != ST_UNLOCK)
                begin
                    e.st.gps = ST_UNLOCK;
                    e = reeval(e, item.now_seconds, item.now_fraction);
                end
                if (e.st.fll_dog <= hold_limit)
                    e.st.fll_dog = e.st.fll_dog + 32'd1;
                if (e.st.fll_dog == hold_limit && e.st.fll != ST_UNLOCK)
                begin
                    e.st.fll = ST_UNLOCK;
                    e = reeval(e, item.now_seconds, item.now_fraction);
                end
            end
            OP_SET_REF:
            begin
                e.st.ref_sec  = item.ref_seconds;
                e.st.ref_frac = item.ref_fraction;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        case (e.st.health)
            H_OK:    run = 1'b1;
            H_HOLD:  run = 1'b0;
            default: run = !(e.st.gps == ST_UNLOCK || e.st.osc == ST_UNLOCK);
        endcase
    end

    assign nxt                  = e.st;
    assign res.health_state     = e.st.health;
    assign res.pps_enabled      = e.st.pps_on;
    assign res.holdover_entered = e.entered;
    assign res.holdover_left    = e.left;
    assign res.holdover_seconds = e.left ? e.secs : 32'd0;
    assign res.run_pll          = run;
    assign res.ref_age_seconds  = age_from(item.now_seconds, item.now_fraction,
                                           e.st.ref_sec, e.st.ref_frac);

endmodule

// File: rtl/core/timing_health_supervisor_top.sv
// Top level of the timing health supervisor: request register, state and
// result registers, holdover limit register. Depends on ths_pkg and ths_step.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tuser op, s_tdata status/ref/now
//  m_*      | out | m_tvalid/m_tready  | m_tdata health, pulses, ages, run_pll
//  cfg_*    | in  | cfg_wr_en          | cfg_wr_data holdover limit (seconds)
//
// One request per cycle sustained unless the result side stalls. Each request
// passes request register, single step (all state updated), result register.
// rst_n resets the supervisor state and the limit (to 3600) and clears both valid flags.
// A stalled result holds in the result register while the request register
// still takes one more request; s_tready drops only when both are full.
module timing_health_supervisor_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [3:0]   s_tuser,     // [3:0] op
    input  logic [135:0] s_tdata,     // [1:0] status_value, [33:2] ref_seconds,
                                      // [65:34] ref_fraction, [97:66] now_seconds,
                                      // [129:98] now_fraction, [135:130] zero
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,     // [1:0] health_state, [2] pps_enabled,
                                      // [3] holdover_entered, [4] holdover_left,
                                      // [36:5] holdover_seconds, [37] run_pll,
                                      // [69:38] ref_age_seconds, [71:70] zero
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data
);
    import ths_pkg::*;

    logic        in_valid_reg, in_valid_next;
    item_t       item_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    sup_state_t  state_reg, state_next;
    result_t     res;
    logic [31:0] limit_reg;
    logic        advance;

    ths_step u_step (
        .item       (item_reg),
        .cur        (state_reg),
        .hold_limit (limit_reg),
        .nxt        (state_next),
        .res        (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            limit_reg          <= HOLD_LIMIT_RST;
            state_reg.pll      <= ST_UNLOCK;
            state_reg.fll      <= ST_UNLOCK;
            state_reg.gps      <= ST_UNLOCK;
            state_reg.osc      <= ST_UNLOCK;
            state_reg.health   <= H_UNLOCK;
            state_reg.ref_sec  <= 32'd0;
            state_reg.ref_frac <= 32'd0;
            state_reg.hold_sec <= ALL_ONES;
            state_reg.hold_frac <= ALL_ONES;
            state_reg.gps_dog  <= 3'd0;
            state_reg.fll_dog  <= ALL_ONES;
            state_reg.pps_on   <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.op           <= s_tuser;
            item_reg.status_value <= s_tdata[1:0];
            item_reg.ref_seconds  <= s_tdata[33:2];
            item_reg.ref_fraction <= s_tdata[65:34];
            item_reg.now_seconds  <= s_tdata[97:66];
            item_reg.now_fraction <= s_tdata[129:98];
        end
        if (advance)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.ref_age_seconds, out_reg.run_pll,
                       out_reg.holdover_seconds, out_reg.holdover_left,
                       out_reg.holdover_entered, out_reg.pps_enabled,
                       out_reg.health_state};

endmodule

// File: bench/tb_top.sv
// Self-checking bench for timing_health_supervisor_top: a directed table, then
// random requests under several idle and stall patterns and holdover limits.
// Depends on ths_pkg and the RTL of timing_health_supervisor_top.
module tb_top;
    import ths_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [3:0]   s_tuser;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic         cfg_wr_en;
    logic [31:0]  cfg_wr_data;

    timing_health_supervisor_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the supervisor, advanced once per accepted request
    sup_state_t  shadow;
    logic [31:0] limit_shadow;
    logic [31:0] now_sec, now_frac;
    logic        saw_entry, saw_exit;
    logic [31:0] exit_secs;

    result_t     pending_status [$];

    int unsigned idle_pct, stall_pct;
    int unsigned hold_ask = 0, hold_taken = 0, stall_left = 0;
    int unsigned mismatches = 0, results_seen = 0, requests, directed_requests;
    int unsigned holdovers_in, holdovers_out, limit_writes;
    logic [31:0] tod_sec, tod_frac;

    typedef struct {
        bit          cfg;    // write the holdover limit (taken from rs) instead
        logic [3:0]  op;
        logic [1:0]  sv;
        logic [31:0] rs, rf, ns, nf;
        bit          typed;
        result_t     want;
    } row_t;

    row_t plan [$];

    function automatic logic [31:0] seconds_since(input logic [31:0] s, input logic [31:0] f);
        logic [31:0] a;
        a = now_sec - s;
        if (now_frac < f)
            a = a - 32'd1;
        return a;
    endfunction

    function automatic void reassess();
        health_t nh;
        nh = shadow.health;
        if (shadow.health == H_OK && shadow.gps == ST_UNLOCK)
        begin
            if (shadow.fll == ST_OK)
                nh = H_HOLD;
            else
                nh = H_UNLOCK;
        end
        if (shadow.health == H_HOLD && shadow.fll == ST_UNLOCK)
            nh = H_UNLOCK;
        if (shadow.health != H_UNLOCK
            && (shadow.pll == ST_UNLOCK || shadow.osc == ST_UNLOCK))
            nh = H_UNLOCK;
        if (shadow.health != H_OK
            && shadow.pll == ST_OK && shadow.gps == ST_OK && shadow.osc == ST_OK)
            nh = H_OK;
        if (nh != shadow.health)
        begin
            if (nh == H_OK)
            begin
                // an all-ones start means nothing was ever captured
                if (shadow.hold_sec != ALL_ONES || shadow.hold_frac != ALL_ONES)
                begin
                    saw_exit  = 1'b1;
                    exit_secs = seconds_since(shadow.hold_sec, shadow.hold_frac);
                end
                shadow.pps_on = 1'b1;
            end
            else if (nh == H_HOLD)
            begin
                shadow.hold_sec  = shadow.ref_sec;
                shadow.hold_frac = shadow.ref_frac;
                saw_entry = 1'b1;
            end
            else
                shadow.pps_on = 1'b0;
            shadow.health = nh;
        end
    endfunction

    function automatic void update_slot(input logic [3:0] which, input logic [1:0] v);
        logic [1:0] cur;
        case (which)
            OP_PLL:  cur = shadow.pll;
            OP_FLL:  cur = shadow.fll;
            OP_GPS:  cur = shadow.gps;
            default: cur = shadow.osc;
        endcase
        if (cur != v)
        begin
            case (which)
                OP_PLL:  shadow.pll = v;
                OP_FLL:  shadow.fll = v;
                OP_GPS:  shadow.gps = v;
                default: shadow.osc = v;
            endcase
            reassess();
        end
    endfunction

    function automatic void second_tick();
        // GPS before FLL; the GPS dog sticks at 4
        if (shadow.gps_dog <= GPS_DOG_LIMIT)
            shadow.gps_dog = shadow.gps_dog + 3'd1;
        if (shadow.gps_dog == GPS_DOG_LIMIT)
            update_slot(OP_GPS, ST_UNLOCK);
        if (shadow.fll_dog <= limit_shadow)
            shadow.fll_dog = shadow.fll_dog + 32'd1;
        if (shadow.fll_dog == limit_shadow)
            update_slot(OP_FLL, ST_UNLOCK);
    endfunction

    function automatic result_t supervise(input logic [3:0] op, input logic [1:0] sv,
                                          input logic [31:0] rs, input logic [31:0] rf,
                                          input logic [31:0] ns, input logic [31:0] nf);
        result_t r;
        now_sec   = ns;
        now_frac  = nf;
        saw_entry = 1'b0;
        saw_exit  = 1'b0;
        exit_secs = '0;
        case (op)
            OP_PLL, OP_FLL, OP_GPS, OP_OSC: update_slot(op, sv);
            OP_KICK_FLL: shadow.fll_dog = '0;
            OP_KICK_GPS: shadow.gps_dog = '0;
            OP_TICK:     second_tick();
            OP_SET_REF:
            begin
                shadow.ref_sec  = rs;
                shadow.ref_frac = rf;
            end
            default: ;
        endcase
        r.health_state     = shadow.health;
        r.pps_enabled      = shadow.pps_on;
        r.holdover_entered = saw_entry;
        r.holdover_left    = saw_exit;
        r.holdover_seconds = saw_exit ? exit_secs : 32'd0;
        if (shadow.health == H_OK)
            r.run_pll = 1'b1;
        else if (shadow.health == H_HOLD)
            r.run_pll = 1'b0;
        else
            r.run_pll = !(shadow.gps == ST_UNLOCK || shadow.osc == ST_UNLOCK);
        r.ref_age_seconds = seconds_since(shadow.ref_sec, shadow.ref_frac);
        holdovers_in  += saw_entry;
        holdovers_out += saw_exit;
        return r;
    endfunction

    function automatic result_t res(input health_t h, input bit pps, input bit ent,
                                    input bit left, input logic [31:0] secs,
                                    input bit run, input logic [31:0] age);
        result_t r;
        r.health_state     = h;
        r.pps_enabled      = pps;
        r.holdover_entered = ent;
        r.holdover_left    = left;
        r.holdover_seconds = secs;
        r.run_pll          = run;
        r.ref_age_seconds  = age;
        return r;
    endfunction

    function automatic row_t req(input logic [3:0] op, input logic [1:0] sv,
                                 input logic [31:0] rs, input logic [31:0] rf,
                                 input logic [31:0] ns, input logic [31:0] nf);
        row_t w;
        w.cfg   = 1'b0;
        w.op    = op;
        w.sv    = sv;
        w.rs    = rs;
        w.rf    = rf;
        w.ns    = ns;
        w.nf    = nf;
        w.typed = 1'b0;
        w.want  = '0;
        return w;
    endfunction

    function automatic row_t fixed(input row_t w, input result_t want);
        row_t o;
        o       = w;
        o.typed = 1'b1;
        o.want  = want;
        return o;
    endfunction

    function automatic row_t lim(input logic [31:0] v);
        row_t w;
        w     = req(OP_QUERY, 2'd0, v, 32'd0, 32'd0, 32'd0);
        w.cfg = 1'b1;
        return w;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d (0x%08h) got %0d (0x%08h)",
                     $time, what, want, want, got, got);
            mismatches++;
        end
    endfunction

    // Result side: check each delivered status, then drive ready for the next edge
    always @(posedge clk)
    begin : status_monitor
        result_t want, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.health_state     = m_tdata[1:0];
            got.pps_enabled      = m_tdata[2];
            got.holdover_entered = m_tdata[3];
            got.holdover_left    = m_tdata[4];
            got.holdover_seconds = m_tdata[36:5];
            got.run_pll          = m_tdata[37];
            got.ref_age_seconds  = m_tdata[69:38];
            results_seen++;
            if (pending_status.size() == 0)
            begin
                $display("%0t: status with no request outstanding, expected none, got 0x%018h",
                         $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("health_state", want.health_state, got.health_state);
                check_field("pps_enabled", want.pps_enabled, got.pps_enabled);
                check_field("holdover_entered", want.holdover_entered,
                            got.holdover_entered);
                check_field("holdover_left", want.holdover_left, got.holdover_left);
                check_field("holdover_seconds", want.holdover_seconds,
                            got.holdover_seconds);
                check_field("run_pll", want.run_pll, got.run_pll);
                check_field("ref_age_seconds", want.ref_age_seconds,
                            got.ref_age_seconds);
            end
        end
        if (hold_ask != hold_taken)
        begin
            hold_taken = hold_ask;
            stall_left = 300;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic offer(input logic [3:0] op, input logic [1:0] sv,
                         input logic [31:0] rs, input logic [31:0] rf,
                         input logic [31:0] ns, input logic [31:0] nf,
                         input bit typed, input result_t want);
        result_t p;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, nf, ns, rf, rs, sv};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        p = supervise(op, sv, rs, rf, ns, nf);
        pending_status.push_back(typed ? want : p);
        requests++;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic write_limit(input logic [31:0] v);
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        limit_shadow = v;
        limit_writes++;
    endtask

    task automatic random_request();
        logic [3:0]  op;
        logic [1:0]  sv;
        logic [31:0] rs, rf, ns, nf;
        int unsigned r;
        r  = $urandom_range(99);
        sv = 2'($urandom);
        rs = $urandom;
        rf = $urandom;
        if (r < 30)
        begin
            op = 4'($urandom_range(3));
            r  = $urandom_range(99);
            sv = (r < 55) ? ST_OK : (r < 85) ? ST_UNLOCK : 2'($urandom_range(3, 2));
        end
        else if (r < 55)
        begin
            op       = OP_TICK;
            tod_sec  = tod_sec + 32'd1;
            tod_frac = $urandom;
        end
        else if (r < 62)
            op = OP_KICK_FLL;
        else if (r < 70)
            op = OP_KICK_GPS;
        else if (r < 80)
        begin
            op = OP_SET_REF;
            if ($urandom_range(99) < 70)
                rs = tod_sec - $urandom_range(30);
        end
        else if (r < 92)
            op = OP_QUERY;
        else
            op = 4'($urandom);
        if ($urandom_range(99) < 75)
        begin
            ns = tod_sec;
            nf = tod_frac;
        end
        else
        begin
            ns = $urandom;
            nf = $urandom;
        end
        offer(op, sv, rs, rf, ns, nf, 1'b0, '0);
    endtask

    initial
    begin : stimulus
        logic [31:0] limits [8];
        logic [3:0]  order  [4];
        int unsigned phase_items;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = '0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        requests    = 0;
        holdovers_in  = 0;
        holdovers_out = 0;
        limit_writes  = 0;
        tod_sec     = 32'd3_900_000_000;
        tod_frac    = '0;

        shadow.pll       = ST_UNLOCK;
        shadow.fll       = ST_UNLOCK;
        shadow.gps       = ST_UNLOCK;
        shadow.osc       = ST_UNLOCK;
        shadow.health    = H_UNLOCK;
        shadow.ref_sec   = '0;
        shadow.ref_frac  = '0;
        shadow.hold_sec  = ALL_ONES;
        shadow.hold_frac = ALL_ONES;
        shadow.gps_dog   = '0;
        shadow.fll_dog   = ALL_ONES;
        shadow.pps_on    = 1'b0;
        limit_shadow     = HOLD_LIMIT_RST;

        limits = '{32'd1, 32'd2, 32'hFFFF_FFFE, 32'd5, 32'd3, HOLD_LIMIT_RST, 32'd7, 32'd4};
        order  = '{OP_PLL, OP_OSC, OP_FLL, OP_GPS};

        // reset state, unused op code, bring-up
        plan.push_back(fixed(req(OP_QUERY, 2'd0, 32'd0, 32'd0, 32'd100, 32'd0),
                             res(H_UNLOCK, 0, 0, 0, 32'd0, 0, 32'd100)));
        plan.push_back(fixed(req(4'd15, 2'd3, ALL_ONES, ALL_ONES, 32'd0, 32'd0),
                             res(H_UNLOCK, 0, 0, 0, 32'd0, 0, 32'd0)));
        plan.push_back(req(OP_PLL, ST_OK, 32'd0, 32'd0, 32'd10, 32'd0));
        plan.push_back(req(OP_OSC, ST_OK, 32'd0, 32'd0, 32'd11, 32'd0));
        plan.push_back(req(OP_GPS, ST_OK, 32'd0, 32'd0, 32'd12, 32'd0));
        plan.push_back(req(OP_FLL, ST_OK, 32'd0, 32'd0, 32'd13, 32'd0));
        plan.push_back(fixed(req(OP_SET_REF, 2'd0, ALL_ONES, ALL_ONES, 32'd0, 32'd0),
                             res(H_OK, 1, 0, 0, 32'd0, 1, 32'd0)));
        // holdover captured as all ones, so leaving it reports nothing
        plan.push_back(req(OP_GPS, ST_UNLOCK, 32'd0, 32'd0, ALL_ONES, ALL_ONES));
        plan.push_back(req(OP_GPS, ST_OK, 32'd0, 32'd0, ALL_ONES, ALL_ONES));
        plan.push_back(req(OP_SET_REF, 2'd0, 32'd1000, 32'd500, 32'd1000, 32'd500));
        // GPS watchdog fires on the third tick, then sticks
        plan.push_back(req(OP_KICK_GPS, 2'd0, 32'd0, 32'd0, 32'd1001, 32'd0));
        plan.push_back(req(OP_TICK, 2'd0, 32'd0, 32'd0, 32'd1002, 32'd0));
        plan.push_back(req(OP_TICK, 2'd0, 32'd0, 32'd0, 32'd1003, 32'd0));
        plan.push_back(req(OP_TICK, 2'd0, 32'd0, 32'd0, 32'd1004, 32'd0));
        plan.push_back(req(OP_TICK, 2'd0, 32'd0, 32'd0, 32'd1005, 32'd0));
        plan.push_back(req(OP_GPS, 2'd3, 32'd0, 32'd0, 32'd1006, 32'd0));
        plan.push_back(req(OP_GPS, ST_OK, 32'd0, 32'd0, 32'd5000, 32'd0));
        // both watchdogs expire on the same tick
        plan.push_back(lim(32'd3));
        plan.push_back(req(OP_KICK_FLL, 2'd0, 32'd0, 32'd0, 32'd5001, 32'd0));
        plan.push_back(req(OP_KICK_GPS, 2'd0, 32'd0, 32'd0, 32'd5001, 32'd0));
        plan.push_back(req(OP_TICK, 2'd0, 32'd0, 32'd0, 32'd5002, 32'd0));
        plan.push_back(req(OP_TICK, 2'd0, 32'd0, 32'd0, 32'd5003, 32'd0));
        plan.push_back(req(OP_TICK, 2'd0, 32'd0, 32'd0, 32'd5004, ALL_ONES));
        // smallest limit: one tick after a kick
        plan.push_back(lim(32'd1));
        plan.push_back(req(OP_FLL, ST_OK, 32'd0, 32'd0, 32'd5005, 32'd0));
        plan.push_back(req(OP_KICK_FLL, 2'd0, 32'd0, 32'd0, 32'd5005, 32'd0));
        plan.push_back(req(OP_TICK, 2'd0, 32'd0, 32'd0, 32'd5006, 32'd0));
        plan.push_back(req(OP_OSC, 2'd2, 32'd0, 32'd0, 32'd5007, 32'd0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].cfg)
                write_limit(plan[i].rs);
            else
                offer(plan[i].op, plan[i].sv, plan[i].rs, plan[i].rf,
                      plan[i].ns, plan[i].nf, plan[i].typed, plan[i].want);
        end
        directed_requests = requests;

        for (int p = 0; p < 8; p++)
        begin
            write_limit(limits[p]);
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 62;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 62;
                end
                default:
                begin
                    idle_pct  = 25;
                    stall_pct = 25;
                end
            endcase
            phase_items = 0;
            while (phase_items < 110)
            begin
                // hold the result side off while requests keep coming
                if (p == 0 && phase_items >= 40 && hold_ask == 0)
                    hold_ask++;
                if ($urandom_range(99) < 6)
                begin
                    for (int k = 0; k < 4; k++)
                        offer(order[k], ST_OK, $urandom, $urandom, tod_sec, tod_frac,
                              1'b0, '0);
                    phase_items += 4;
                end
                else
                begin
                    random_request();
                    phase_items++;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d requests (%0d directed) over %0d limit settings; %0d statuses checked.",
                 requests, directed_requests, limit_writes, results_seen);
        $display("Predicted %0d holdover entries and %0d holdover exits with a duration.",
                 holdovers_in, holdovers_out);
        if (mismatches == 0 && pending_status.size() == 0)
            $display("** timing_health_supervisor_top: PASSED **");
        else
            $display("** timing_health_supervisor_top: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("timeout with %0d statuses outstanding", pending_status.size());
        $display("** timing_health_supervisor_top: FAILED **");
        $finish;
    end

endmodule
